### rtl/core/ftas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftas_pkg
// Shared types and constants for the flow table aging sweeper: item structs,
// register indexes, policy levels and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package ftas_pkg;

    localparam int AGE_W      = 8;
    localparam int PCT_W      = 7;
    localparam int IN_IDX_W   = 10;
    localparam int OUT_CNT_W  = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int PCT_SCALE  = 100;

    localparam logic [AGE_W-1:0] AGE_MAX = 8'hFF;

    localparam logic [AGE_W-1:0] AGE_LIMIT_LOW_RST  = 8'd3;
    localparam logic [AGE_W-1:0] AGE_LIMIT_MID_RST  = 8'd2;
    localparam logic [AGE_W-1:0] AGE_LIMIT_HIGH_RST = 8'd1;
    localparam logic [PCT_W-1:0] MID_PERCENT_RST    = 7'd70;
    localparam logic [PCT_W-1:0] HIGH_PERCENT_RST   = 7'd90;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AGE_LIMIT_LOW  = 3'd0,
        CFG_AGE_LIMIT_MID  = 3'd1,
        CFG_AGE_LIMIT_HIGH = 3'd2,
        CFG_MID_PERCENT    = 3'd3,
        CFG_HIGH_PERCENT   = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        LEVEL_LOW  = 2'd0,
        LEVEL_MID  = 2'd1,
        LEVEL_HIGH = 2'd2
    } level_t;

    typedef struct packed {
        logic                kind;
        logic [IN_IDX_W-1:0] entry_index;
        logic                entry_valid;
        logic [AGE_W-1:0]    entry_age;
    } in_item_t;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] checked_count;
        logic [OUT_CNT_W-1:0] freed_count;
        logic [1:0]           level_after;
        logic [OUT_CNT_W-1:0] occupancy;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic wr_rd;
        logic wr_upd;
        logic sweep_rd;
        logic lvl_mul;
        logic lvl_set;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic sweep_end;
    } status_t;

endpackage

`default_nettype wire

### rtl/core/flow_table_aging_sweeper.sv
// Sequence: a write request reads, then updates its entry before its result is loaded;
//   a tick sweeps SEG_SIZE = ENTRIES/PERIOD entries, one per cycle, and sets the level.
// Flow: one request in flight; the next is taken once its result is registered.
// Reset: synchronous, active low; a clearing pass over all ENTRIES entries then zeroes
//   the entry memory with s_ready low. Configuration writes are taken during that pass.
`default_nettype none
// ----------------------------------------------------------------------------
// flow_table_aging_sweeper
// Flow table aging: per-entry writes and segment sweeps that age entries,
// free stale ones and pick the aging policy level from occupancy.
// ----------------------------------------------------------------------------
module flow_table_aging_sweeper #(
    parameter int ENTRIES = 1024,
    parameter int PERIOD  = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [ftas_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ftas_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire ftas_pkg::in_item_t              s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output ftas_pkg::out_item_t                  m_data
);

    ftas_pkg::cmd_t    cmd;
    ftas_pkg::status_t status;

    ftas_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_data.kind),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    ftas_dp #(
        .ENTRIES (ENTRIES),
        .PERIOD  (PERIOD)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

`ifndef ASSERT_OFF
    // no request may be taken while the clearing pass runs
    a_no_accept_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request ready during clearing pass");

    a_freed_le_checked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.freed_count <= m_data.checked_count))
        else $error("freed count exceeds checked count");

    a_valid_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.out_load))
        else $error("result valid without result load");
`endif

endmodule

`default_nettype wire

### rtl/core/ftas_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftas_ctrl
// Sequencer for the aging sweeper: clearing pass, write read-modify-write,
// segment sweep, level update and result hand-off.
// ----------------------------------------------------------------------------
module ftas_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_kind,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ftas_pkg::cmd_t         cmd,
    input  wire ftas_pkg::status_t status
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_RD,
        ST_WR_UPD,
        ST_SWEEP,
        ST_LVL_MUL,
        ST_LVL_SET,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   load_ok;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        load_ok      = !m_valid_reg || m_ready;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = (s_kind == ftas_pkg::KIND_TICK) ? ST_SWEEP : ST_WR_RD;
                end
            end
            ST_WR_RD: begin
                cmd.wr_rd  = 1'b1;
                state_next = ST_WR_UPD;
            end
            ST_WR_UPD: begin
                cmd.wr_upd = 1'b1;
                state_next = ST_DONE;
            end
            ST_SWEEP: begin
                // last entry retires in the same cycle the pointer hits the end
                if (status.sweep_end) begin
                    state_next = ST_LVL_MUL;
                end else begin
                    cmd.sweep_rd = 1'b1;
                end
            end
            ST_LVL_MUL: begin
                cmd.lvl_mul = 1'b1;
                state_next  = ST_LVL_SET;
            end
            ST_LVL_SET: begin
                cmd.lvl_set = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (load_ok) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

### rtl/core/ftas_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftas_dp
// Datapath: entry memory (valid bit and age per entry), sweep pointer,
// counters, occupancy, policy level, configuration and result registers.
// ----------------------------------------------------------------------------
module ftas_dp #(
    parameter int ENTRIES = 1024,
    parameter int PERIOD  = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_we,
    input  wire logic [ftas_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [ftas_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  wire ftas_pkg::in_item_t                    s_data,
    output ftas_pkg::out_item_t                        m_data,
    input  wire ftas_pkg::cmd_t                        cmd,
    output ftas_pkg::status_t                          status
);

    localparam int AGE_W    = ftas_pkg::AGE_W;
    localparam int PCT_W    = ftas_pkg::PCT_W;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int PTR_W    = IDX_W + 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int PROD_W   = CNT_W + PCT_W;
    localparam int SEG_SIZE = ENTRIES / PERIOD;
    localparam int SEG_W    = (PERIOD > 1) ? $clog2(PERIOD) : 1;
    localparam int CMP_W    = (PTR_W > ftas_pkg::IN_IDX_W) ? PTR_W : ftas_pkg::IN_IDX_W;
    localparam int MEM_W    = AGE_W + 1;

    // configuration
    logic [AGE_W-1:0] age_low_reg, age_mid_reg, age_high_reg;
    logic [PCT_W-1:0] mid_pct_reg, high_pct_reg;

    // entry memory: {valid, age}
    logic [MEM_W-1:0] mem [ENTRIES];
    logic [MEM_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [MEM_W-1:0] mem_wdata;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    ftas_pkg::in_item_t  item_reg;
    ftas_pkg::out_item_t out_reg;
    ftas_pkg::level_t    level_reg, level_next;

    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [PTR_W-1:0]  end_reg;
    logic              pipe_vld_reg;
    logic [IDX_W-1:0]  pipe_addr_reg;
    logic [CNT_W-1:0]  checked_reg, checked_next;
    logic [CNT_W-1:0]  freed_reg, freed_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [SEG_W-1:0]  seg_reg, seg_next;
    logic [PTR_W-1:0]  seg_start_reg, seg_start_next;
    logic [PROD_W-1:0] used_reg, thr_hi_reg, thr_mid_reg;

    logic [CMP_W-1:0]  idx_ext;
    logic              in_range;
    logic [IDX_W-1:0]  item_addr;
    logic              seg_last;
    logic [PTR_W-1:0]  seg_end;
    logic [AGE_W-1:0]  limit;
    logic [AGE_W-1:0]  age_inc;
    logic              entry_live;
    logic              do_free;
    logic              old_valid;
    logic              tick_start;

    assign idx_ext    = CMP_W'(item_reg.entry_index);
    assign in_range   = idx_ext < CMP_W'(ENTRIES);
    assign item_addr  = idx_ext[IDX_W-1:0];
    assign seg_last   = (seg_reg == SEG_W'(PERIOD - 1));
    // last segment takes the remainder of the table
    assign seg_end    = seg_last ? PTR_W'(ENTRIES) : seg_start_reg + PTR_W'(SEG_SIZE);
    assign old_valid  = rd_data_reg[AGE_W];
    assign age_inc    = (rd_data_reg[AGE_W-1:0] == ftas_pkg::AGE_MAX) ?
                        ftas_pkg::AGE_MAX : rd_data_reg[AGE_W-1:0] + 1'b1;
    assign entry_live = pipe_vld_reg && old_valid;
    assign do_free    = entry_live && (age_inc > limit);
    assign tick_start = cmd.accept && (s_data.kind == ftas_pkg::KIND_TICK);

    always_comb begin
        case (level_reg)
            ftas_pkg::LEVEL_LOW:  limit = age_low_reg;
            ftas_pkg::LEVEL_MID:  limit = age_mid_reg;
            ftas_pkg::LEVEL_HIGH: limit = age_high_reg;
            default:              limit = age_low_reg;
        endcase
    end

    // memory write port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = ptr_reg[IDX_W-1:0];
        mem_wdata = '0;
        if (cmd.clr_step) begin
            mem_we = 1'b1;
        end else if (cmd.wr_upd) begin
            mem_we    = in_range;
            mem_waddr = item_addr;
            mem_wdata = {item_reg.entry_valid, item_reg.entry_age};
        end else if (entry_live) begin
            mem_we    = 1'b1;
            mem_waddr = pipe_addr_reg;
            mem_wdata = {!do_free, age_inc};
        end
    end

    assign rd_en   = cmd.wr_rd || cmd.sweep_rd;
    assign rd_addr = cmd.wr_rd ? item_addr : ptr_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        total_next = total_reg;
        if (cmd.wr_upd && in_range) begin
            if (item_reg.entry_valid && !old_valid) begin
                total_next = total_reg + 1'b1;
            end else if (!item_reg.entry_valid && old_valid) begin
                total_next = total_reg - 1'b1;
            end
        end else if (do_free) begin
            total_next = total_reg - 1'b1;
        end
    end

    always_comb begin
        checked_next = checked_reg;
        freed_next   = freed_reg;
        if (cmd.accept) begin
            checked_next = '0;
            freed_next   = '0;
        end else begin
            if (entry_live) begin
                checked_next = checked_reg + 1'b1;
            end
            if (do_free) begin
                freed_next = freed_reg + 1'b1;
            end
        end
    end

    always_comb begin
        ptr_next = ptr_reg;
        if (tick_start) begin
            ptr_next = seg_start_reg;
        end else if (cmd.clr_step || cmd.sweep_rd) begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    always_comb begin
        seg_next       = seg_reg;
        seg_start_next = seg_start_reg;
        level_next     = level_reg;
        if (cmd.lvl_set) begin
            if (seg_last) begin
                seg_next       = '0;
                seg_start_next = '0;
            end else begin
                seg_next       = seg_reg + 1'b1;
                seg_start_next = seg_start_reg + PTR_W'(SEG_SIZE);
            end
            if (used_reg > thr_hi_reg) begin
                level_next = ftas_pkg::LEVEL_HIGH;
            end else if (used_reg > thr_mid_reg) begin
                level_next = ftas_pkg::LEVEL_MID;
            end else begin
                level_next = ftas_pkg::LEVEL_LOW;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg       <= '0;
            pipe_vld_reg  <= 1'b0;
            total_reg     <= '0;
            seg_reg       <= '0;
            seg_start_reg <= '0;
            level_reg     <= ftas_pkg::LEVEL_LOW;
            age_low_reg   <= ftas_pkg::AGE_LIMIT_LOW_RST;
            age_mid_reg   <= ftas_pkg::AGE_LIMIT_MID_RST;
            age_high_reg  <= ftas_pkg::AGE_LIMIT_HIGH_RST;
            mid_pct_reg   <= ftas_pkg::MID_PERCENT_RST;
            high_pct_reg  <= ftas_pkg::HIGH_PERCENT_RST;
        end else begin
            ptr_reg       <= ptr_next;
            pipe_vld_reg  <= cmd.sweep_rd;
            total_reg     <= total_next;
            seg_reg       <= seg_next;
            seg_start_reg <= seg_start_next;
            level_reg     <= level_next;
            if (cfg_we) begin
                case (ftas_pkg::cfg_reg_t'(cfg_index))
                    ftas_pkg::CFG_AGE_LIMIT_LOW:  age_low_reg  <= cfg_wdata;
                    ftas_pkg::CFG_AGE_LIMIT_MID:  age_mid_reg  <= cfg_wdata;
                    ftas_pkg::CFG_AGE_LIMIT_HIGH: age_high_reg <= cfg_wdata;
                    ftas_pkg::CFG_MID_PERCENT:    mid_pct_reg  <= cfg_wdata[PCT_W-1:0];
                    ftas_pkg::CFG_HIGH_PERCENT:   high_pct_reg <= cfg_wdata[PCT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_data;
        end
        if (tick_start) begin
            end_reg <= seg_end;
        end
        pipe_addr_reg <= ptr_reg[IDX_W-1:0];
        checked_reg   <= checked_next;
        freed_reg     <= freed_next;
        if (cmd.lvl_mul) begin
            used_reg    <= PROD_W'(total_reg) * PROD_W'(ftas_pkg::PCT_SCALE);
            thr_hi_reg  <= PROD_W'(ENTRIES) * PROD_W'(high_pct_reg);
            thr_mid_reg <= PROD_W'(ENTRIES) * PROD_W'(mid_pct_reg);
        end
        if (cmd.out_load) begin
            out_reg.checked_count <= ftas_pkg::OUT_CNT_W'(checked_reg);
            out_reg.freed_count   <= ftas_pkg::OUT_CNT_W'(freed_reg);
            out_reg.level_after   <= level_reg;
            out_reg.occupancy     <= ftas_pkg::OUT_CNT_W'(total_reg);
        end
    end

    assign status.clr_last  = (ptr_reg == PTR_W'(ENTRIES - 1));
    assign status.sweep_end = (ptr_reg == end_reg);
    assign m_data           = out_reg;

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for flow_table_aging_sweeper. A directed table with
// hand-computed results comes first, then randomized phases. Each phase uses
// its own aging limits, occupancy thresholds and handshake idling. Every
// accepted request goes through a local table-aging predictor, and each result
// is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ENTRIES     = 1024;
    localparam int PERIOD      = 16;
    localparam int SEG         = ENTRIES / PERIOD;
    localparam int CLK_PERIOD  = 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int TICK_PCT    = 20;

    localparam logic [ftas_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    typedef struct packed {
        ftas_pkg::in_item_t  req;
        logic                typed;
        ftas_pkg::out_item_t want;
    } dir_row_t;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            cfg_we;
    logic [ftas_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ftas_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                            s_valid;
    logic                            s_ready;
    ftas_pkg::in_item_t              s_data;
    logic                            m_valid;
    logic                            m_ready;
    ftas_pkg::out_item_t             m_data;

    // predictor state
    bit                         valid_map [0:ENTRIES-1];
    logic [ftas_pkg::AGE_W-1:0] entry_ages [0:ENTRIES-1];
    int unsigned                sweep_seg;
    ftas_pkg::level_t           cur_level;
    int unsigned                live_count;
    logic [ftas_pkg::AGE_W-1:0] lim_low, lim_mid, lim_high;
    logic [ftas_pkg::PCT_W-1:0] pct_mid, pct_high;

    ftas_pkg::out_item_t expected_results[$];
    dir_row_t            dir_rows[$];
    logic                pinned_valid;
    ftas_pkg::out_item_t pinned_result;

    int mismatches   = 0;
    int cycle_count  = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_req     = 0;
    int hold_left    = 0;

    flow_table_aging_sweeper #(
        .ENTRIES(ENTRIES),
        .PERIOD (PERIOD)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic int unsigned level_limit();
        case (cur_level)
            ftas_pkg::LEVEL_HIGH: return 32'(lim_high);
            ftas_pkg::LEVEL_MID:  return 32'(lim_mid);
            default:              return 32'(lim_low);
        endcase
    endfunction

    function automatic ftas_pkg::out_item_t age_table_step(ftas_pkg::in_item_t req);
        ftas_pkg::out_item_t res;
        int unsigned first, last, lim, idx, visited, evicted, used;
        visited = 0;
        evicted = 0;
        if (req.kind == ftas_pkg::KIND_WRITE) begin
            idx = 32'(req.entry_index);
            if (idx < ENTRIES) begin
                if (req.entry_valid && !valid_map[idx])
                    live_count++;
                else if (!req.entry_valid && valid_map[idx])
                    live_count--;
                valid_map[idx]  = req.entry_valid;
                entry_ages[idx] = req.entry_age;
            end
        end else begin
            first = sweep_seg * SEG;
            last  = (sweep_seg == PERIOD - 1) ? ENTRIES : first + SEG;
            lim   = level_limit();
            for (int i = first; i < last; i++) begin
                if (valid_map[i]) begin
                    visited++;
                    if (entry_ages[i] != ftas_pkg::AGE_MAX)
                        entry_ages[i]++;
                    if (32'(entry_ages[i]) > lim) begin
                        valid_map[i] = 1'b0;
                        live_count--;
                        evicted++;
                    end
                end
            end
            sweep_seg = (sweep_seg == PERIOD - 1) ? 0 : sweep_seg + 1;
            used = live_count * ftas_pkg::PCT_SCALE;
            if (used > ENTRIES * 32'(pct_high))
                cur_level = ftas_pkg::LEVEL_HIGH;
            else if (used > ENTRIES * 32'(pct_mid))
                cur_level = ftas_pkg::LEVEL_MID;
            else
                cur_level = ftas_pkg::LEVEL_LOW;
        end
        res.checked_count = ftas_pkg::OUT_CNT_W'(visited);
        res.freed_count   = ftas_pkg::OUT_CNT_W'(evicted);
        res.level_after   = cur_level;
        res.occupancy     = ftas_pkg::OUT_CNT_W'(live_count);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // config writes, accepted requests and results, all seen at the rising edge
    always @(posedge aclk) begin
        ftas_pkg::out_item_t model, want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            if (aresetn && cfg_we) begin
                case (cfg_index)
                    ftas_pkg::CFG_AGE_LIMIT_LOW:  lim_low  = cfg_wdata;
                    ftas_pkg::CFG_AGE_LIMIT_MID:  lim_mid  = cfg_wdata;
                    ftas_pkg::CFG_AGE_LIMIT_HIGH: lim_high = cfg_wdata;
                    ftas_pkg::CFG_MID_PERCENT:    pct_mid  = cfg_wdata[ftas_pkg::PCT_W-1:0];
                    ftas_pkg::CFG_HIGH_PERCENT:   pct_high = cfg_wdata[ftas_pkg::PCT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                model = age_table_step(s_data);
                expected_results.push_back(pinned_valid ? pinned_result : model);
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_data);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("checked_count", 16'(want.checked_count),
                                16'(m_data.checked_count));
                    check_field("freed_count", 16'(want.freed_count),
                                16'(m_data.freed_count));
                    check_field("level_after", 16'(want.level_after),
                                16'(m_data.level_after));
                    check_field("occupancy", 16'(want.occupancy),
                                16'(m_data.occupancy));
                end
            end
        end
    end

    // result side: random stalls plus an occasional long hold-off
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_request(input ftas_pkg::in_item_t req, input logic typed,
                                input ftas_pkg::out_item_t want);
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_data        <= req;
        pinned_valid  = typed;
        pinned_result = want;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    task automatic wait_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic [ftas_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ftas_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic add_row(input logic kind, input int idx, input logic vld, input int age,
                           input logic typed, input int chk, input int frd,
                           input ftas_pkg::level_t lvl, input int occ);
        dir_row_t r;
        r.req.kind            = kind;
        r.req.entry_index     = ftas_pkg::IN_IDX_W'(idx);
        r.req.entry_valid     = vld;
        r.req.entry_age       = ftas_pkg::AGE_W'(age);
        r.typed               = typed;
        r.want.checked_count  = ftas_pkg::OUT_CNT_W'(chk);
        r.want.freed_count    = ftas_pkg::OUT_CNT_W'(frd);
        r.want.level_after    = lvl;
        r.want.occupancy      = ftas_pkg::OUT_CNT_W'(occ);
        dir_rows.push_back(r);
    endtask

    // writes lean toward the segment that the next tick sweeps, ages toward the limit
    function automatic ftas_pkg::in_item_t rand_request();
        ftas_pkg::in_item_t req;
        req.kind        = ($urandom_range(99) < TICK_PCT) ? ftas_pkg::KIND_TICK
                                                          : ftas_pkg::KIND_WRITE;
        req.entry_index = ftas_pkg::IN_IDX_W'($urandom_range(1) ?
                              sweep_seg * SEG + $urandom_range(SEG - 1)
                            : $urandom_range(ENTRIES - 1));
        req.entry_valid = ($urandom_range(99) < 80);
        case ($urandom_range(3))
            0:       req.entry_age = 8'd0;
            1:       req.entry_age = ftas_pkg::AGE_MAX;
            2:       req.entry_age = ftas_pkg::AGE_W'(level_limit() - 1 + $urandom_range(2));
            default: req.entry_age = ftas_pkg::AGE_W'($urandom_range(255));
        endcase
        return req;
    endfunction

    task automatic run_phase(input logic [7:0] lo, input logic [7:0] md, input logic [7:0] hi,
                             input logic [7:0] pm, input logic [7:0] ph, input int items,
                             input int tx, input int rx, input bit hold, input bit pause);
        write_reg(ftas_pkg::CFG_AGE_LIMIT_LOW, lo);
        write_reg(ftas_pkg::CFG_AGE_LIMIT_MID, md);
        write_reg(ftas_pkg::CFG_AGE_LIMIT_HIGH, hi);
        write_reg(ftas_pkg::CFG_MID_PERCENT, pm);
        write_reg(ftas_pkg::CFG_HIGH_PERCENT, ph);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
        for (int k = 0; k < items; k++) begin
            if (k == items / 2 && hold)
                hold_req = 1;
            if (k == items / 2 && pause)
                wait_results();
            if ($urandom_range(99) < tx_idle_pct)
                idle_cycles($urandom_range(1, 4));
            send_request(rand_request(), 1'b0, '0);
        end
        wait_results();
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = ftas_pkg::CFG_AGE_LIMIT_LOW;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_data        = '0;
        pinned_valid  = 1'b0;
        pinned_result = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            valid_map[i]  = 1'b0;
            entry_ages[i] = '0;
        end
        sweep_seg  = 0;
        cur_level  = ftas_pkg::LEVEL_LOW;
        live_count = 0;
        lim_low    = ftas_pkg::AGE_LIMIT_LOW_RST;
        lim_mid    = ftas_pkg::AGE_LIMIT_MID_RST;
        lim_high   = ftas_pkg::AGE_LIMIT_HIGH_RST;
        pct_mid    = ftas_pkg::MID_PERCENT_RST;
        pct_high   = ftas_pkg::HIGH_PERCENT_RST;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // tick rows carry junk in the write fields; they must be ignored
        add_row(ftas_pkg::KIND_TICK,  1023, 1, 255, 1, 0, 0, ftas_pkg::LEVEL_LOW, 0);
        add_row(ftas_pkg::KIND_WRITE, 1023, 1, 255, 1, 0, 0, ftas_pkg::LEVEL_LOW, 1);
        add_row(ftas_pkg::KIND_WRITE,    0, 1,   0, 1, 0, 0, ftas_pkg::LEVEL_LOW, 2);
        add_row(ftas_pkg::KIND_WRITE,    0, 1, 200, 1, 0, 0, ftas_pkg::LEVEL_LOW, 2);
        add_row(ftas_pkg::KIND_WRITE,    1, 0,   0, 1, 0, 0, ftas_pkg::LEVEL_LOW, 2);
        add_row(ftas_pkg::KIND_WRITE,   64, 1,   0, 1, 0, 0, ftas_pkg::LEVEL_LOW, 3);
        add_row(ftas_pkg::KIND_WRITE,   65, 1,   2, 1, 0, 0, ftas_pkg::LEVEL_LOW, 4);
        add_row(ftas_pkg::KIND_WRITE,   66, 1,   3, 1, 0, 0, ftas_pkg::LEVEL_LOW, 5);
        add_row(ftas_pkg::KIND_WRITE,  127, 1, 255, 1, 0, 0, ftas_pkg::LEVEL_LOW, 6);
        add_row(ftas_pkg::KIND_WRITE,  128, 1, 254, 1, 0, 0, ftas_pkg::LEVEL_LOW, 7);
        // segment 1: age 3 and saturated 255 go past the low limit
        add_row(ftas_pkg::KIND_TICK,  1023, 1, 255, 1, 4, 2, ftas_pkg::LEVEL_LOW, 5);
        add_row(ftas_pkg::KIND_TICK,     0, 0,   0, 1, 1, 1, ftas_pkg::LEVEL_LOW, 4);
        add_row(ftas_pkg::KIND_WRITE,   64, 0,   0, 1, 0, 0, ftas_pkg::LEVEL_LOW, 3);
        add_row(ftas_pkg::KIND_WRITE,    1, 1, 170, 0, 0, 0, ftas_pkg::LEVEL_LOW, 0);
        add_row(ftas_pkg::KIND_WRITE,  682, 1,  85, 0, 0, 0, ftas_pkg::LEVEL_LOW, 0);
        add_row(ftas_pkg::KIND_WRITE,  341, 1,  85, 0, 0, 0, ftas_pkg::LEVEL_LOW, 0);
        add_row(ftas_pkg::KIND_WRITE,  192, 1,   1, 0, 0, 0, ftas_pkg::LEVEL_LOW, 0);
        add_row(ftas_pkg::KIND_TICK,   682, 0, 170, 0, 0, 0, ftas_pkg::LEVEL_LOW, 0);
        foreach (dir_rows[i])
            send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        wait_results();

        run_phase(8'd3,   8'd2,   8'd1,   8'd70,  8'd90,  100,  0,  0, 0, 0);
        // everything visited gets freed; also a write to an unmapped index
        write_reg(CFG_NO_REG, 8'hFF);
        run_phase(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   100, 62,  0, 0, 0);
        run_phase(8'd255, 8'd255, 8'd255, 8'd5,   8'd10,  120,  0, 62, 1, 0);
        // thresholds at and past 100 percent never select their level
        run_phase(8'd254, 8'd10,  8'd1,   8'd127, 8'hE4,  120, 23, 23, 0, 0);
        run_phase(8'd20,  8'd5,   8'd2,   8'd8,   8'd15,  130,  0,  0, 0, 1);
        run_phase(8'd3,   8'd2,   8'd1,   8'd70,  8'd90,  130, 23, 23, 0, 0);

        repeat (SEG + 16) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d results missing, expected %h, actual none", $time,
                     expected_results.size(), expected_results[0]);
            mismatches++;
        end
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### flow_table_aging_sweeper.f
rtl/core/ftas_pkg.sv
rtl/core/ftas_ctrl.sv
rtl/core/ftas_dp.sv
rtl/core/flow_table_aging_sweeper.sv
verif/testbench.sv
